/* src/nsa_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsa_pkg
// Shared types, widths and codes for the nearest seed search block.
// ---------------------------------------------------------------------------
package nsa_pkg;

  localparam int MAX_SEEDS   = 1024;
  localparam int COORD_BITS  = 16;
  localparam int LABEL_W     = 6;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int INDEX_OUT_W = 10;

  localparam int IDX_W   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int FILL_W  = $clog2(MAX_SEEDS + 1);
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DIST_W  = SQ_W + 2;
  localparam int SEED_W  = 3 * COORD_BITS + LABEL_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // func codes on the item channel
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_QUERY = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = FUNC_W'(2);

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ANSWERED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_STORED   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_NONE     = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_CLEARED  = STATUS_W'(4);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DRAIN
  } bstate_t;

  typedef struct packed {
    op_t                           op;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic signed [COORD_BITS-1:0]  z;
    logic [LABEL_W-1:0]            label;
  } cmd_t;

  // front -> back handshake
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  // back status, seen by the top level
  typedef struct packed {
    logic              busy;
    logic [FILL_W-1:0] fill;
  } bstat_t;

endpackage

/* src/nsa_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module nsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/nsa_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsa_front
// Takes items, decodes func into an operation and queues it for the back end.
// ---------------------------------------------------------------------------
module nsa_front
  import nsa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [FUNC_W-1:0]             func,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic [LABEL_W-1:0]            seed_label,
  output cmd_chan_t                     cmd_out,
  input  logic                          cmd_pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              accept;
  logic              known;
  op_t               op_dec;
  logic              push;
  logic              pop;

  // func 3 is taken and dropped: it yields no result
  always_comb begin
    known  = 1'b1;
    op_dec = OP_LOAD;
    unique case (func)
      FUNC_LOAD:  op_dec = OP_LOAD;
      FUNC_QUERY: op_dec = OP_QUERY;
      FUNC_CLEAR: op_dec = OP_CLEAR;
      default:    known  = 1'b0;
    endcase
  end

  assign item_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign accept     = item_valid && !item_stall;
  assign push       = accept && known;
  assign pop        = cmd_pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: op_dec, x: coord_x, y: coord_y, z: coord_z,
                           label: seed_label};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign cmd_out.valid = (count != '0);
  assign cmd_out.cmd   = entries[rd_ptr];

endmodule

/* src/nsa_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsa_back
// Executes queued operations: seed table writes, clears and the query scan
// through a pipelined distance unit, and holds the result register.
// ---------------------------------------------------------------------------
module nsa_back
  import nsa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_chan_t                  cmd_in,
  output logic                       cmd_pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [INDEX_OUT_W-1:0]     nearest_index,
  output logic [LABEL_W-1:0]         nearest_label,
  output logic [DIST_W-1:0]          distance_sq,
  output bstat_t                     stat
);

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? (~d + 1'b1) : d;
    return m[COORD_BITS-1:0];
  endfunction

  bstate_t state;
  bstate_t state_next;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] scan_cnt;
  logic              full;
  logic              start;
  logic              issue;
  logic              last_issue;
  logic              pipe_busy;
  logic              finish;
  logic              ram_we;
  logic [SEED_W-1:0] ram_rdata;

  logic signed [COORD_BITS-1:0] q_x;
  logic signed [COORD_BITS-1:0] q_y;
  logic signed [COORD_BITS-1:0] q_z;

  // stage 1: RAM read data
  logic              p1_v;
  logic [IDX_W-1:0]  p1_idx;
  // stage 2: absolute differences
  logic              p2_v;
  logic [IDX_W-1:0]  p2_idx;
  logic [LABEL_W-1:0] p2_lab;
  logic [COORD_BITS-1:0] p2_dx;
  logic [COORD_BITS-1:0] p2_dy;
  logic [COORD_BITS-1:0] p2_dz;
  // stage 3: squares
  logic              p3_v;
  logic [IDX_W-1:0]  p3_idx;
  logic [LABEL_W-1:0] p3_lab;
  logic [SQ_W-1:0]   p3_sx;
  logic [SQ_W-1:0]   p3_sy;
  logic [SQ_W-1:0]   p3_sz;
  // stage 4: sum
  logic              p4_v;
  logic [IDX_W-1:0]  p4_idx;
  logic [LABEL_W-1:0] p4_lab;
  logic [DIST_W-1:0] p4_sum;
  // running best
  logic              best_have;
  logic [IDX_W-1:0]  best_idx;
  logic [LABEL_W-1:0] best_lab;
  logic [DIST_W-1:0] best_d;

  logic signed [COORD_BITS-1:0] r_x;
  logic signed [COORD_BITS-1:0] r_y;
  logic signed [COORD_BITS-1:0] r_z;
  logic [LABEL_W-1:0]           r_lab;

  assign r_x   = ram_rdata[COORD_BITS-1:0];
  assign r_y   = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign r_z   = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign r_lab = ram_rdata[SEED_W-1:3*COORD_BITS];

  assign full       = (fill == FILL_W'(MAX_SEEDS));
  assign last_issue = (scan_cnt == fill - FILL_W'(1));
  assign pipe_busy  = p1_v || p2_v || p3_v || p4_v;

  nsa_ram #(
    .WIDTH (SEED_W),
    .DEPTH (MAX_SEEDS)
  ) u_seed_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[IDX_W-1:0]),
    .wdata ({cmd_in.cmd.label, cmd_in.cmd.z, cmd_in.cmd.y, cmd_in.cmd.x}),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (start && cmd_in.cmd.op == OP_QUERY && fill != '0) begin
          state_next = BS_SCAN;
        end
      end
      BS_SCAN: begin
        if (last_issue) begin
          state_next = BS_DRAIN;
        end
      end
      BS_DRAIN: begin
        if (!pipe_busy) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    start  = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state)
      BS_IDLE:  start  = cmd_in.valid && !result_valid;
      BS_SCAN:  issue  = 1'b1;
      BS_DRAIN: finish = !pipe_busy;
      default:  start  = 1'b0;
    endcase
  end

  assign cmd_pop = start;
  assign ram_we  = start && (cmd_in.cmd.op == OP_LOAD) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table fill, scan counter, query point
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (start) begin
      unique case (cmd_in.cmd.op)
        OP_LOAD:  if (!full) fill <= fill + FILL_W'(1);
        OP_CLEAR: fill <= '0;
        default:  fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scan_cnt <= '0;
      q_x      <= cmd_in.cmd.x;
      q_y      <= cmd_in.cmd.y;
      q_z      <= cmd_in.cmd.z;
    end else if (issue) begin
      scan_cnt <= scan_cnt + FILL_W'(1);
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= scan_cnt[IDX_W-1:0];

    p2_idx <= p1_idx;
    p2_lab <= r_lab;
    p2_dx  <= abs_diff(q_x, r_x);
    p2_dy  <= abs_diff(q_y, r_y);
    p2_dz  <= abs_diff(q_z, r_z);

    p3_idx <= p2_idx;
    p3_lab <= p2_lab;
    p3_sx  <= SQ_W'(p2_dx) * SQ_W'(p2_dx);
    p3_sy  <= SQ_W'(p2_dy) * SQ_W'(p2_dy);
    p3_sz  <= SQ_W'(p2_dz) * SQ_W'(p2_dz);

    p4_idx <= p3_idx;
    p4_lab <= p3_lab;
    p4_sum <= DIST_W'(p3_sx) + DIST_W'(p3_sy) + DIST_W'(p3_sz);
  end

  // strict less-than keeps the earliest seed on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      best_have <= 1'b0;
    end else if (start) begin
      best_have <= 1'b0;
    end else if (p4_v) begin
      best_have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p4_v && (!best_have || p4_sum < best_d)) begin
      best_d   <= p4_sum;
      best_idx <= p4_idx;
      best_lab <= p4_lab;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (start) begin
      unique case (cmd_in.cmd.op)
        OP_QUERY: result_valid <= (fill == '0);
        default:  result_valid <= 1'b1;
      endcase
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      distance_sq <= '0;
      unique case (cmd_in.cmd.op)
        OP_LOAD: begin
          if (full) begin
            status        <= ST_FULL;
            nearest_index <= '0;
            nearest_label <= '0;
          end else begin
            status        <= ST_STORED;
            nearest_index <= INDEX_OUT_W'(fill);
            nearest_label <= cmd_in.cmd.label;
          end
        end
        OP_QUERY: begin
          status        <= ST_NONE;
          nearest_index <= '0;
          nearest_label <= '0;
        end
        default: begin
          status        <= ST_CLEARED;
          nearest_index <= '0;
          nearest_label <= '0;
        end
      endcase
    end else if (finish) begin
      status        <= ST_ANSWERED;
      nearest_index <= INDEX_OUT_W'(best_idx);
      nearest_label <= best_lab;
      distance_sq   <= best_d;
    end
  end

  assign stat.busy = (state != BS_IDLE);
  assign stat.fill = fill;

endmodule

/* src/nearest_seed_assign.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_seed_assign
// Brute-force 3-D nearest seed search over a table of up to MAX_SEEDS seeds.
// ---------------------------------------------------------------------------
// Usage:
//   Items come in on item_valid/item_stall with func, coord_x/y/z (Q2.13)
//   and seed_label. A transfer takes place when valid is high and stall low.
//   func 0 appends a seed, 1 queries a point, 2 clears the table; func 3 is
//   taken and dropped without a result. Every other item gives exactly one
//   result on result_valid/result_stall: status, nearest_index,
//   nearest_label and distance_sq (squared distance, unsigned Q8.26).
//   A load, clear or query on an empty table is answered through the result
//   register that the back end loads when it takes the item; a query is
//   answered once the scan has drained, since the back end reads one seed
//   per cycle from the seed RAM and runs it through a four-stage distance
//   pipeline (difference, square, sum, compare). The back end takes no new
//   item while a query is scanned or a result is pending. A four-entry queue
//   separates the input side from the back end, so items keep transferring
//   while a query is scanned or a result waits. While result_stall is high
//   the result register holds.
//   Reset empties the queue and the table (fill count to zero) and drops
//   any pending result; seed RAM contents are not cleared.
// ---------------------------------------------------------------------------
module nearest_seed_assign
  import nsa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [FUNC_W-1:0]             func,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic [LABEL_W-1:0]            seed_label,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [STATUS_W-1:0]           status,
  output logic [INDEX_OUT_W-1:0]        nearest_index,
  output logic [LABEL_W-1:0]            nearest_label,
  output logic [DIST_W-1:0]             distance_sq
);

  cmd_chan_t cmd_chan;
  logic      cmd_pop;
  bstat_t    back_stat;

  // front end: decode and queue
  nsa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .seed_label (seed_label),
    .cmd_out    (cmd_chan),
    .cmd_pop    (cmd_pop)
  );

  // back end: seed table, scan pipeline, result register
  nsa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_in        (cmd_chan),
    .cmd_pop       (cmd_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .nearest_index (nearest_index),
    .nearest_label (nearest_label),
    .distance_sq   (distance_sq),
    .stat          (back_stat)
  );

  // fill count never passes the table depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    back_stat.fill <= FILL_W'(MAX_SEEDS))
    else $error("seed fill count above table depth");

  // no result may be pending while a query scan runs
  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    back_stat.busy |-> !result_valid)
    else $error("result pending during scan");

  // a pop only happens when the queue holds an entry
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_chan.valid)
    else $error("pop from empty queue");

  // a load that stores grows the table by one
  a_load_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd_chan.cmd.op == OP_LOAD && back_stat.fill != FILL_W'(MAX_SEEDS))
    |=> back_stat.fill == $past(back_stat.fill) + FILL_W'(1))
    else $error("load did not advance fill count");

  // after reset no result is shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

/* sim/tb_nearest_seed_assign.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_seed_assign
// Self-checking bench for the brute-force 3-D nearest seed search. Loads,
// queries and clears are pushed through the item channel under random idle
// gaps and result back-pressure. Each transfer is run through a local model
// of the seed table, and every result is checked field by field in order.
// ---------------------------------------------------------------------------
module tb_nearest_seed_assign;
  import nsa_pkg::*;

  // Upper bound on the run.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_ITEMS = 540;
  localparam int          SQUEEZE_AT   = 250;   // results seen before the long hold-off
  localparam int          SQUEEZE_LEN  = 300;   // cycles the receiver refuses results
  localparam int          TAIL_CYCLES  = 100;   // quiet time after the last result

  // func 3 is legal on the bus but does nothing
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = FUNC_W'(3);

  typedef struct {
    logic [FUNC_W-1:0]            fn;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [LABEL_W-1:0]           tag;
  } seed_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [INDEX_OUT_W-1:0] idx;
    logic [LABEL_W-1:0]     tag;
    logic [DIST_W-1:0]      dsq;
  } answer_t;

  // DUT ports; every input starts at a known value
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         item_valid = 1'b0;
  logic                         item_stall;
  logic [FUNC_W-1:0]            func = '0;
  logic signed [COORD_BITS-1:0] coord_x = '0;
  logic signed [COORD_BITS-1:0] coord_y = '0;
  logic signed [COORD_BITS-1:0] coord_z = '0;
  logic [LABEL_W-1:0]           seed_label = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic [STATUS_W-1:0]          status;
  logic [INDEX_OUT_W-1:0]       nearest_index;
  logic [LABEL_W-1:0]           nearest_label;
  logic [DIST_W-1:0]            distance_sq;

  // Items waiting to be driven, and answers waiting to come out
  seed_item_t pending[$];
  answer_t    answers_due[$];

  // Local copy of the seed table; only slots below seed_count are ever read
  logic signed [COORD_BITS-1:0] seed_x [MAX_SEEDS];
  logic signed [COORD_BITS-1:0] seed_y [MAX_SEEDS];
  logic signed [COORD_BITS-1:0] seed_z [MAX_SEEDS];
  logic [LABEL_W-1:0]           seed_tag [MAX_SEEDS];
  int unsigned                  seed_count = 0;

  // Mirror of the table kept by the stimulus builder, used to aim queries
  // at stored seeds and to plant duplicates
  logic signed [COORD_BITS-1:0] gen_x [MAX_SEEDS];
  logic signed [COORD_BITS-1:0] gen_y [MAX_SEEDS];
  logic signed [COORD_BITS-1:0] gen_z [MAX_SEEDS];
  int unsigned                  gen_fill = 0;

  bit [31:0]   cycle_count = 0;
  logic        item_fire = 1'b0;   // item transfer at the last rising edge
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          squeeze_done = 1'b0;
  seed_item_t  next_item;

  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned n_answered = 0;
  int unsigned n_refused = 0;

  nearest_seed_assign dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .func          (func),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .seed_label    (seed_label),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .nearest_index (nearest_index),
    .nearest_label (nearest_label),
    .distance_sq   (distance_sq)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Square of one coordinate difference, exact in 64 bits
  function automatic longint span_sq(input logic signed [COORD_BITS-1:0] a,
                                     input logic signed [COORD_BITS-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    return diff * diff;
  endfunction

  // Apply one transfer to the local table and work out its result.
  // made is cleared for func 3, which leaves no result behind.
  task automatic assign_nearest(input logic [FUNC_W-1:0] fn,
                                input logic signed [COORD_BITS-1:0] px,
                                input logic signed [COORD_BITS-1:0] py,
                                input logic signed [COORD_BITS-1:0] pz,
                                input logic [LABEL_W-1:0] tag,
                                output bit made, output answer_t ans);
    longint best_d;
    longint d;
    int     best_k;
    ans  = '0;
    made = 1'b1;
    case (fn)
      FUNC_LOAD: begin
        if (seed_count >= MAX_SEEDS) begin
          // table full: seed dropped, everything else reads zero
          ans.status = ST_FULL;
          n_refused++;
        end else begin
          seed_x[seed_count]   = px;
          seed_y[seed_count]   = py;
          seed_z[seed_count]   = pz;
          seed_tag[seed_count] = tag;
          ans.status = ST_STORED;
          ans.idx    = INDEX_OUT_W'(seed_count);
          ans.tag    = tag;
          seed_count++;
        end
      end
      FUNC_QUERY: begin
        if (seed_count == 0) begin
          ans.status = ST_NONE;
        end else begin
          best_d = 0;
          best_k = 0;
          // strict less-than: the earliest of equal distances is kept
          for (int k = 0; k < seed_count; k++) begin
            d = span_sq(px, seed_x[k]) + span_sq(py, seed_y[k]) + span_sq(pz, seed_z[k]);
            if (k == 0 || d < best_d) begin
              best_d = d;
              best_k = k;
            end
          end
          ans.status = ST_ANSWERED;
          ans.idx    = INDEX_OUT_W'(best_k);
          ans.tag    = seed_tag[best_k];
          ans.dsq    = DIST_W'(best_d);
          n_answered++;
        end
      end
      FUNC_CLEAR: begin
        // stale seeds stay in the stores but are no longer reachable
        seed_count = 0;
        ans.status = ST_CLEARED;
      end
      default: made = 1'b0;
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Queue one item and keep the builder's view of the table in step
  task automatic queue_item(input logic [FUNC_W-1:0] fn,
                            input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic signed [COORD_BITS-1:0] z,
                            input logic [LABEL_W-1:0] tag);
    seed_item_t it;
    it.fn  = fn;
    it.x   = x;
    it.y   = y;
    it.z   = z;
    it.tag = tag;
    pending.insert(pending.size(), it);
    if (fn == FUNC_LOAD && gen_fill < MAX_SEEDS) begin
      gen_x[gen_fill] = x;
      gen_y[gen_fill] = y;
      gen_z[gen_fill] = z;
      gen_fill++;
    end else if (fn == FUNC_CLEAR) begin
      gen_fill = 0;
    end
  endtask

  // Idle run length: mostly none, some short, a few long
  function automatic int unsigned idle_span(input bit calm);
    int unsigned r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: presents queued items at the falling edge; a payload holds until
  // its transfer, then an idle gap may follow
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else if (!item_valid || item_fire) begin
      if (gap_left != 0) begin
        item_valid <= 1'b0;
        gap_left--;
      end else if (pending.size() != 0) begin
        next_item = pending.pop_front();
        func       <= next_item.fn;
        coord_x    <= next_item.x;
        coord_y    <= next_item.y;
        coord_z    <= next_item.z;
        seed_label <= next_item.tag;
        item_valid <= 1'b1;
        // the sender runs without gaps for one stretch in four
        gap_left = idle_span(cycle_count[9:8] == 2'b00);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver back-pressure: random stall runs, plus one long hold-off that
  // lets the input queue fill and stall the sender
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      squeeze_done = 1'b1;
      hold_left = SQUEEZE_LEN - 1;
      result_stall <= 1'b1;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = idle_span(cycle_count[10:9] == 2'b01);
      if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks result transfers against the oldest expectation, then
  // runs item transfers through the predictor
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    answer_t fresh;
    bit      made;
    if (rst) begin
      item_fire <= 1'b0;
    end else begin
      item_fire <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          $error("result with nothing expected: status %0d index %0d", status,
                 nearest_index);
          err_count++;
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            err_count++;
          end
          if (nearest_index !== want.idx) begin
            $error("nearest_index: expected %0d, actual %0d", want.idx, nearest_index);
            err_count++;
          end
          if (nearest_label !== want.tag) begin
            $error("nearest_label: expected %0d, actual %0d", want.tag, nearest_label);
            err_count++;
          end
          if (distance_sq !== want.dsq) begin
            $error("distance_sq: expected %0d, actual %0d", want.dsq, distance_sq);
            err_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        items_taken++;
        assign_nearest(func, coord_x, coord_y, coord_z, seed_label, made, fresh);
        if (made)
          answers_due.insert(answers_due.size(), fresh);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run limit of %0d cycles reached, %0d results still due", CYCLE_LIMIT,
             answers_due.size());
      $display("nearest_seed_assign test failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin
    int                           counted;
    int                           r;
    int                           mode;
    int                           pick;
    int unsigned                  fill_cap;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] sz;

    // ---- directed: empty table, extremes, ties, ignored func, tag range
    queue_item(FUNC_QUERY, 16'sd0, 16'sd0, 16'sd0, 6'd0);          // no seeds yet
    queue_item(FUNC_CLEAR, 16'sd0, 16'sd0, 16'sd0, 6'd0);          // clear when empty
    queue_item(FUNC_UNUSED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'h3F); // no result
    queue_item(FUNC_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 6'd0);
    queue_item(FUNC_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd9);  // largest distance
    queue_item(FUNC_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd50);
    queue_item(FUNC_LOAD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'h3F); // same point, tag 63
    queue_item(FUNC_QUERY, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd0);  // tie, slot 1 wins
    queue_item(FUNC_LOAD, 16'sd0, 16'sd0, 16'sd0, 6'd51);
    queue_item(FUNC_LOAD, 16'sd2, 16'sd0, 16'sd0, 6'd52);
    queue_item(FUNC_QUERY, 16'sd1, 16'sd0, 16'sd0, 6'd0);           // equidistant seeds
    queue_item(FUNC_QUERY, -16'sd1, -16'sd1, -16'sd1, 6'd0);
    queue_item(FUNC_QUERY, 16'sh8000, 16'sh7FFF, 16'sd0, 6'h3F);
    queue_item(FUNC_UNUSED, 16'sd0, 16'sd0, 16'sd0, 6'd0);
    queue_item(FUNC_CLEAR, 16'sh1234, 16'sh5678, 16'sh7ABC, 6'd7);
    queue_item(FUNC_QUERY, 16'sd0, 16'sd0, 16'sd0, 6'd0);           // stale seeds unseen
    queue_item(FUNC_LOAD, -16'sd1, -16'sd1, -16'sd1, 6'd21);        // slot 0 reused
    queue_item(FUNC_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 6'd0);
    queue_item(FUNC_LOAD, 16'sh5555, 16'sh5555, 16'sh5555, 6'h2A);
    queue_item(FUNC_QUERY, 16'shAAAA, 16'shAAAA, 16'shAAAA, 6'h15);
    queue_item(FUNC_CLEAR, 16'sd0, 16'sd0, 16'sd0, 6'd0);

    // ---- random: small tables so queries stay short, queries mostly aimed
    // at or near stored seeds, duplicates for ties, a little func 3 noise
    counted  = 0;
    fill_cap = $urandom_range(4, 48);
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        queue_item(FUNC_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), LABEL_W'($urandom));
      end else begin
        counted++;
        if (r < 10 || (r < 50 && gen_fill >= fill_cap)) begin
          queue_item(FUNC_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), LABEL_W'($urandom));
          fill_cap = $urandom_range(1, 48);
        end else if (r < 50) begin
          mode = $urandom_range(0, 3);
          if (mode == 0 && gen_fill != 0) begin
            pick = $urandom_range(0, gen_fill - 1);
            sx = gen_x[pick];
            sy = gen_y[pick];
            sz = gen_z[pick];
          end else if (mode == 1) begin
            sx = COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            sy = COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            sz = COORD_BITS'(int'($urandom_range(0, 16)) - 8);
          end else begin
            sx = COORD_BITS'($urandom);
            sy = COORD_BITS'($urandom);
            sz = COORD_BITS'($urandom);
          end
          queue_item(FUNC_LOAD, sx, sy, sz, LABEL_W'($urandom));
        end else begin
          mode = $urandom_range(0, 4);
          if (mode <= 2 && gen_fill != 0) begin
            pick = $urandom_range(0, gen_fill - 1);
            sx = gen_x[pick];
            sy = gen_y[pick];
            sz = gen_z[pick];
            if (mode != 0) begin
              sx = sx + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
              sy = sy + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
              sz = sz + COORD_BITS'(int'($urandom_range(0, 6)) - 3);
            end
          end else begin
            sx = COORD_BITS'($urandom);
            sy = COORD_BITS'($urandom);
            sz = COORD_BITS'($urandom);
          end
          queue_item(FUNC_QUERY, sx, sy, sz, LABEL_W'($urandom));
        end
      end
    end

    // ---- reset once, then run until everything has come back
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || item_valid || answers_due.size() != 0)
      @(posedge clk);
    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items transferred, %0d results checked, %0d nearest-seed answers,",
             items_taken, results_seen, n_answered);
    $display("%0d loads refused on a full table, %0d mismatches", n_refused, err_count);
    if (err_count == 0)
      $display("nearest_seed_assign test passed");
    else
      $display("nearest_seed_assign test failed");
    $finish;
  end

endmodule
